### rtl/core/stop_order_trigger_pool_assert.svh
// Assertion macros for the pool RTL, included by sotp_back; clk and arst_n come from the module using them.
`ifndef STOP_ORDER_TRIGGER_POOL_ASSERT_SVH
`define STOP_ORDER_TRIGGER_POOL_ASSERT_SVH

// same-cycle implication
`define SOTP_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sotp assertion failed");

// next-cycle implication
`define SOTP_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("sotp assertion failed");

`endif

### rtl/core/sotp_pkg.sv
`default_nettype none
package sotp_pkg;

	typedef enum logic [1:0] {
		FN_SUBMIT = 2'd0,
		FN_CANCEL = 2'd1,
		FN_EXPIRE = 2'd2,
		FN_TRADE  = 2'd3
	} func_t;

	typedef enum logic [3:0] {
		RES_ACCEPTED  = 4'd0,
		RES_BAD_PARAM = 4'd1,
		RES_MKT_LIMIT = 4'd2,
		RES_LIM_MISS  = 4'd3,
		RES_POOL_FULL = 4'd4,
		RES_CANCELLED = 4'd5,
		RES_NOT_FOUND = 4'd6,
		RES_EXPIRED   = 4'd7,
		RES_TRIGGERED = 4'd8
	} res_t;

	// classified command passed from front to back
	typedef struct packed {
		func_t              func;
		res_t               res;
		logic               kind;
		logic [1:0]         side;
		logic signed [31:0] trig;
		logic signed [31:0] lim;
		logic [31:0]        qty;
		logic [63:0]        tval;   // expiry for submit, now for sweep
		logic [31:0]        id;
		logic signed [31:0] tp;
	} cmd_t;

	// one stored stop
	typedef struct packed {
		logic [31:0]        id;
		logic               side;
		logic               kind;
		logic signed [31:0] trig;
		logic signed [31:0] lim;
		logic [31:0]        qty;
		logic [63:0]        expiry;
	} slot_t;

	typedef struct packed {
		res_t               res;
		logic [31:0]        id;
		logic [1:0]         side;
		logic               kind;
		logic signed [31:0] trig;
		logic signed [31:0] reis;
		logic [31:0]        qty;
	} rslt_t;

endpackage
`default_nettype wire

### rtl/core/sotp_ram.sv
`default_nettype none
module sotp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  wire logic                                       clk,
	input  wire logic                                       we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                           wdata,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                           rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

### rtl/core/sotp_front.sv
`default_nettype none
module sotp_front (
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [1:0]         func,
	input  wire logic               stop_kind,
	input  wire logic [1:0]         side,
	input  wire logic signed [31:0] trig_px,
	input  wire logic signed [31:0] lmt_px,
	input  wire logic [31:0]        quantity,
	input  wire logic [63:0]        time_to_live,
	input  wire logic [63:0]        now_time,
	input  wire logic [31:0]        ord_ref,
	input  wire logic signed [31:0] trade_price,
	output logic                    cmd_valid,
	input  wire logic               cmd_ready,
	output sotp_pkg::cmd_t          cmd
);
	import sotp_pkg::*;

	logic [64:0] exp_sum;
	logic [63:0] expiry;
	logic        drop;
	res_t        chk;

	assign exp_sum = {1'b0, now_time} + {1'b0, time_to_live};

	always_comb begin
		if (time_to_live == 64'd0) begin
			expiry = 64'd0;
		end else if (exp_sum[64]) begin
			expiry = '1;
		end else begin
			expiry = exp_sum[63:0];
		end
	end

	always_comb begin
		if (quantity == 32'd0 || side > 2'd1 || trig_px <= 32'sd0) begin
			chk = RES_BAD_PARAM;
		end else if (!stop_kind && lmt_px != 32'sd0) begin
			chk = RES_MKT_LIMIT;
		end else if (stop_kind && lmt_px <= 32'sd0) begin
			chk = RES_LIM_MISS;
		end else begin
			chk = RES_ACCEPTED;
		end
	end

	// a trade at price zero fires nothing: take it and drop it here
	assign drop = (func_t'(func) == FN_TRADE) && (trade_price == 32'sd0);

	assign cmd_valid = in_valid && !drop;
	assign in_ready  = cmd_ready || drop;

	always_comb begin
		cmd.func = func_t'(func);
		cmd.res  = chk;
		cmd.kind = stop_kind;
		cmd.side = side;
		cmd.trig = trig_px;
		cmd.lim  = lmt_px;
		cmd.qty  = quantity;
		cmd.tval = (func_t'(func) == FN_SUBMIT) ? expiry : now_time;
		cmd.id   = ord_ref;
		cmd.tp   = trade_price;
	end
endmodule
`default_nettype wire

### rtl/core/sotp_queue.sv
`default_nettype none
module sotp_queue (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      push_valid,
	output logic           push_ready,
	input  sotp_pkg::cmd_t push_data,
	output logic           pop_valid,
	input  wire logic      pop,
	output sotp_pkg::cmd_t pop_data
);
	import sotp_pkg::*;

	cmd_t       ent_q [2];
	logic       wp_q;
	logic       rp_q;
	logic [1:0] cnt_q;
	logic       do_push;
	logic       do_pop;

	assign push_ready = (cnt_q != 2'd2);
	assign pop_valid  = (cnt_q != 2'd0);
	assign pop_data   = ent_q[rp_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop && pop_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			ent_q[wp_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (do_push) begin
				wp_q <= !wp_q;
			end
			if (do_pop) begin
				rp_q <= !rp_q;
			end
			cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
		end
	end
endmodule
`default_nettype wire

### rtl/core/sotp_back.sv
`default_nettype none
module sotp_back #(
	parameter int MAX_STOPS = 32
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      cmd_valid,
	output logic           cmd_pop,
	input  sotp_pkg::cmd_t cmd,
	output logic           out_valid,
	input  wire logic      out_ready,
	output sotp_pkg::rslt_t rslt,
	output logic           rslt_last
);
	import sotp_pkg::*;

	localparam int IW = (MAX_STOPS > 1) ? $clog2(MAX_STOPS) : 1;
	localparam logic [IW-1:0] LAST_IDX = IW'(MAX_STOPS - 1);

	typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_EVAL, ST_FLUSH} st_t;

	st_t                  st_q;
	cmd_t                 cmd_q;
	logic [IW-1:0]        idx_q;
	logic [MAX_STOPS-1:0] active_q;
	rslt_t                pend_q;
	logic                 pend_vq;
	rslt_t                out_q;
	logic                 out_vq;
	logic                 out_last_q;

	slot_t  rd_slot;
	slot_t  wr_slot;
	logic   ram_we;
	logic   push_ok;
	logic   hit;
	logic   at_end;
	rslt_t  hit_r;
	rslt_t  sub_r;
	rslt_t  nf_r;

	sotp_ram #(
		.WIDTH($bits(slot_t)),
		.DEPTH(MAX_STOPS)
	) u_slots (
		.clk  (clk),
		.we   (ram_we),
		.waddr(idx_q),
		.wdata(wr_slot),
		.raddr(idx_q),
		.rdata(rd_slot)
	);

	assign cmd_pop   = (st_q == ST_IDLE) && cmd_valid;
	assign push_ok   = !out_vq || out_ready;
	assign at_end    = (idx_q == LAST_IDX);
	assign ram_we    = (st_q == ST_SCAN) && (cmd_q.func == FN_SUBMIT) && !active_q[idx_q];
	assign out_valid = out_vq;
	assign rslt      = out_q;
	assign rslt_last = out_last_q;

	always_comb begin
		wr_slot.id     = cmd_q.id;
		wr_slot.side   = cmd_q.side[0];
		wr_slot.kind   = cmd_q.kind;
		wr_slot.trig   = cmd_q.trig;
		wr_slot.lim    = cmd_q.lim;
		wr_slot.qty    = cmd_q.qty;
		wr_slot.expiry = cmd_q.tval;
	end

	always_comb begin
		case (cmd_q.func)
			FN_CANCEL: hit = (rd_slot.id == cmd_q.id);
			FN_EXPIRE: hit = (rd_slot.expiry != 64'd0) && (rd_slot.expiry <= cmd_q.tval);
			FN_TRADE:  hit = rd_slot.side ? (cmd_q.tp <= rd_slot.trig)
			                              : (cmd_q.tp >= rd_slot.trig);
			default:   hit = 1'b0;
		endcase
	end

	always_comb begin
		case (cmd_q.func)
			FN_CANCEL: hit_r.res = RES_CANCELLED;
			FN_EXPIRE: hit_r.res = RES_EXPIRED;
			default:   hit_r.res = RES_TRIGGERED;
		endcase
		hit_r.id   = rd_slot.id;
		hit_r.side = {1'b0, rd_slot.side};
		hit_r.kind = rd_slot.kind;
		hit_r.trig = rd_slot.trig;
		hit_r.reis = (cmd_q.func == FN_TRADE && rd_slot.kind) ? rd_slot.lim : 32'sd0;
		hit_r.qty  = rd_slot.qty;

		sub_r.res  = cmd_q.res;
		sub_r.id   = 32'd0;
		sub_r.side = cmd_q.side;
		sub_r.kind = cmd_q.kind;
		sub_r.trig = cmd_q.trig;
		sub_r.reis = 32'sd0;
		sub_r.qty  = cmd_q.qty;

		nf_r      = '0;
		nf_r.res  = RES_NOT_FOUND;
		nf_r.id   = cmd_q.id;
	end

	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			cmd_q <= cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q       <= ST_IDLE;
			idx_q      <= '0;
			active_q   <= '0;
			pend_vq    <= 1'b0;
			pend_q     <= '0;
			out_vq     <= 1'b0;
			out_q      <= '0;
			out_last_q <= 1'b0;
		end else begin
			if (out_vq && out_ready) begin
				out_vq <= 1'b0;
			end
			case (st_q)
				ST_IDLE: begin
					if (cmd_valid) begin
						idx_q <= '0;
						if (cmd.func == FN_SUBMIT && cmd.res != RES_ACCEPTED) begin
							pend_q      <= '0;
							pend_q.res  <= cmd.res;
							pend_q.side <= cmd.side;
							pend_q.kind <= cmd.kind;
							pend_q.trig <= cmd.trig;
							pend_q.qty  <= cmd.qty;
							pend_vq     <= 1'b1;
							st_q        <= ST_FLUSH;
						end else begin
							st_q <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					if (cmd_q.func == FN_SUBMIT) begin
						if (!active_q[idx_q]) begin
							active_q[idx_q] <= 1'b1;
							pend_q          <= sub_r;
							pend_q.id       <= cmd_q.id;
							pend_vq         <= 1'b1;
							st_q            <= ST_FLUSH;
						end else if (at_end) begin
							pend_q     <= sub_r;
							pend_q.res <= RES_POOL_FULL;
							pend_vq    <= 1'b1;
							st_q       <= ST_FLUSH;
						end else begin
							idx_q <= idx_q + 1'b1;
						end
					end else if (active_q[idx_q]) begin
						// read data for this slot shows up next cycle
						st_q <= ST_EVAL;
					end else if (at_end) begin
						if (cmd_q.func == FN_CANCEL) begin
							pend_q  <= nf_r;
							pend_vq <= 1'b1;
						end
						st_q <= ST_FLUSH;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				ST_EVAL: begin
					if (hit && cmd_q.func == FN_CANCEL) begin
						active_q[idx_q] <= 1'b0;
						pend_q          <= hit_r;
						pend_vq         <= 1'b1;
						st_q            <= ST_FLUSH;
					end else if (hit && pend_vq && !push_ok) begin
						st_q <= ST_EVAL;
					end else begin
						if (hit) begin
							// hand the previous hit out; it is not the final one
							if (pend_vq) begin
								out_q      <= pend_q;
								out_last_q <= 1'b0;
								out_vq     <= 1'b1;
							end
							active_q[idx_q] <= 1'b0;
							pend_q          <= hit_r;
							pend_vq         <= 1'b1;
						end
						if (at_end) begin
							if (cmd_q.func == FN_CANCEL) begin
								pend_q  <= nf_r;
								pend_vq <= 1'b1;
							end
							st_q <= ST_FLUSH;
						end else begin
							idx_q <= idx_q + 1'b1;
							st_q  <= ST_SCAN;
						end
					end
				end
				ST_FLUSH: begin
					if (!pend_vq) begin
						st_q <= ST_IDLE;
					end else if (push_ok) begin
						out_q      <= pend_q;
						out_last_q <= 1'b1;
						out_vq     <= 1'b1;
						pend_vq    <= 1'b0;
						st_q       <= ST_IDLE;
					end
				end
				default: begin
					st_q <= ST_IDLE;
				end
			endcase
		end
	end

`include "stop_order_trigger_pool_assert.svh"

	`SOTP_ASSERT_IMP(a_idle_no_pend, st_q == ST_IDLE, !pend_vq)
	`SOTP_ASSERT_IMP(a_write_free_slot, ram_we, !active_q[idx_q])
	`SOTP_ASSERT_NXT(a_write_sets_active, ram_we, active_q[$past(idx_q)])
	`SOTP_ASSERT_IMP(a_flush_has_result,
		st_q == ST_FLUSH && (cmd_q.func == FN_SUBMIT || cmd_q.func == FN_CANCEL), pend_vq)
endmodule
`default_nettype wire

### rtl/core/stop_order_trigger_pool.sv
// channel | direction | handshake            | payload
// in      | inbound   | in_valid / in_ready   | func .. trade_price
// out     | outbound  | out_valid / out_ready | event_res .. event_quantity, last
//
// A submit result follows a free-slot scan of the slot valid bits, one slot per cycle; a
// rejected submit skips the scan and goes straight to its result.
// Cancel, sweep and trade read each active slot from the registered-read slot memory and
// then compare it before moving on; inactive slots are skipped without a compare.
// Reset clears all slot valid bits at once; slot memory contents need no clearing.
// A stalled output holds the scan when a further hit is found and holds the final beat.
`default_nettype none
module stop_order_trigger_pool #(
	parameter int MAX_STOPS = 32
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [1:0]         func,
	input  wire logic               stop_kind,
	input  wire logic [1:0]         side,
	input  wire logic signed [31:0] trig_px,
	input  wire logic signed [31:0] lmt_px,
	input  wire logic [31:0]        quantity,
	input  wire logic [63:0]        time_to_live,
	input  wire logic [63:0]        now_time,
	input  wire logic [31:0]        ord_ref,
	input  wire logic signed [31:0] trade_price,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic [3:0]              event_res,
	output logic [31:0]             event_order_id,
	output logic [1:0]              event_side,
	output logic                    event_kind,
	output logic signed [31:0]      event_trigger_price,
	output logic signed [31:0]      reissue_price,
	output logic [31:0]             event_quantity,
	output logic                    last
);
	import sotp_pkg::*;

	cmd_t  f_cmd;
	logic  f_valid;
	logic  f_ready;
	cmd_t  q_cmd;
	logic  q_valid;
	logic  q_pop;
	rslt_t rslt;

	sotp_front u_front (
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.func         (func),
		.stop_kind    (stop_kind),
		.side         (side),
		.trig_px      (trig_px),
		.lmt_px       (lmt_px),
		.quantity     (quantity),
		.time_to_live (time_to_live),
		.now_time     (now_time),
		.ord_ref      (ord_ref),
		.trade_price  (trade_price),
		.cmd_valid    (f_valid),
		.cmd_ready    (f_ready),
		.cmd          (f_cmd)
	);

	sotp_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(f_valid),
		.push_ready(f_ready),
		.push_data (f_cmd),
		.pop_valid (q_valid),
		.pop       (q_pop),
		.pop_data  (q_cmd)
	);

	sotp_back #(
		.MAX_STOPS(MAX_STOPS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_valid(q_valid),
		.cmd_pop  (q_pop),
		.cmd      (q_cmd),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.rslt     (rslt),
		.rslt_last(last)
	);

	assign event_res           = rslt.res;
	assign event_order_id      = rslt.id;
	assign event_side          = rslt.side;
	assign event_kind          = rslt.kind;
	assign event_trigger_price = rslt.trig;
	assign reissue_price       = rslt.reis;
	assign event_quantity      = rslt.qty;
endmodule
`default_nettype wire

### dv/stop_order_trigger_pool_test.sv
module stop_order_trigger_pool_test;
	timeunit 1ns;
	timeprecision 1ps;
	import sotp_pkg::*;

	localparam int POOL_DEPTH = 32;

	typedef struct {
		func_t              fn;
		logic               kind;
		logic [1:0]         sd;
		logic signed [31:0] trig;
		logic signed [31:0] lim;
		logic [31:0]        qty;
		logic [63:0]        ttl;
		logic [63:0]        now_t;
		logic [31:0]        id;
		logic signed [31:0] tp;
	} order_cmd_t;

	typedef struct {
		res_t               res;
		logic [31:0]        id;
		logic [1:0]         sd;
		logic               kind;
		logic signed [31:0] trig;
		logic signed [31:0] reis;
		logic [31:0]        qty;
		logic               lst;
	} pool_event_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [1:0] func = '0;
	logic stop_kind = 1'b0;
	logic [1:0] side = '0;
	logic signed [31:0] trig_px = '0;
	logic signed [31:0] lmt_px = '0;
	logic [31:0] quantity = '0;
	logic [63:0] time_to_live = '0;
	logic [63:0] now_time = '0;
	logic [31:0] ord_ref = '0;
	logic signed [31:0] trade_price = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [3:0] event_res;
	logic [31:0] event_order_id;
	logic [1:0] event_side;
	logic event_kind;
	logic signed [31:0] event_trigger_price;
	logic signed [31:0] reissue_price;
	logic [31:0] event_quantity;
	logic last;

	stop_order_trigger_pool u_dut (.*);

	always #10 clk = ~clk;

	order_cmd_t  cmd_queue[$];
	pool_event_t expected_events[$];
	int errors = 0;
	bit calm = 1'b0;
	bit hold_sender = 1'b0;
	bit stim_done = 1'b0;

	// shadow pool
	bit                 pool_active[POOL_DEPTH];
	logic [31:0]        pool_id[POOL_DEPTH];
	logic               pool_side[POOL_DEPTH];
	logic               pool_kind[POOL_DEPTH];
	logic signed [31:0] pool_trig[POOL_DEPTH];
	logic signed [31:0] pool_lim[POOL_DEPTH];
	logic [31:0]        pool_qty[POOL_DEPTH];
	logic [63:0]        pool_exp[POOL_DEPTH];
	logic [31:0]        live_ids[$];

	function automatic pool_event_t slot_event(int i, res_t r, logic signed [31:0] reis);
		pool_event_t e;
		e.res = r; e.id = pool_id[i]; e.sd = {1'b0, pool_side[i]}; e.kind = pool_kind[i];
		e.trig = pool_trig[i]; e.reis = reis; e.qty = pool_qty[i]; e.lst = 1'b0;
		return e;
	endfunction

	task automatic predict_pool(input order_cmd_t c);
		pool_event_t ev[$];
		pool_event_t e;
		int free_slot;
		logic [64:0] sum;
		bit fire;
		free_slot = -1;
		case (c.fn)
			FN_SUBMIT: begin
				e.res = RES_ACCEPTED;
				if (c.qty == 0 || c.sd > 1 || c.trig <= 0)
					e.res = RES_BAD_PARAM;
				else if (!c.kind && c.lim != 0)
					e.res = RES_MKT_LIMIT;
				else if (c.kind && c.lim <= 0)
					e.res = RES_LIM_MISS;
				else begin
					for (int i = 0; i < POOL_DEPTH; i++)
						if (!pool_active[i] && free_slot < 0) free_slot = i;
					if (free_slot < 0) e.res = RES_POOL_FULL;
				end
				if (e.res == RES_ACCEPTED) begin
					sum = {1'b0, c.now_t} + {1'b0, c.ttl};
					pool_active[free_slot] = 1'b1;
					pool_id[free_slot] = c.id;
					pool_side[free_slot] = c.sd[0];
					pool_kind[free_slot] = c.kind;
					pool_trig[free_slot] = c.trig;
					pool_lim[free_slot] = c.lim;
					pool_qty[free_slot] = c.qty;
					pool_exp[free_slot] = (c.ttl == 0) ? 64'd0 : (sum[64] ? '1 : sum[63:0]);
					live_ids.push_back(c.id);
				end
				e.id = (e.res == RES_ACCEPTED) ? c.id : 32'd0;
				e.sd = c.sd; e.kind = c.kind; e.trig = c.trig; e.reis = '0; e.qty = c.qty;
				ev.push_back(e);
			end
			FN_CANCEL: begin
				for (int i = 0; i < POOL_DEPTH; i++)
					if (ev.size() == 0 && pool_active[i] && pool_id[i] == c.id) begin
						pool_active[i] = 1'b0;
						ev.push_back(slot_event(i, RES_CANCELLED, '0));
					end
				if (ev.size() == 0) begin
					e = '{RES_NOT_FOUND, c.id, 2'd0, 1'b0, '0, '0, '0, 1'b0};
					ev.push_back(e);
				end
			end
			FN_EXPIRE: begin
				for (int i = 0; i < POOL_DEPTH; i++)
					if (pool_active[i] && pool_exp[i] != 0 && pool_exp[i] <= c.now_t) begin
						pool_active[i] = 1'b0;
						ev.push_back(slot_event(i, RES_EXPIRED, '0));
					end
			end
			default: begin
				if (c.tp != 0)
					for (int i = 0; i < POOL_DEPTH; i++) begin
						fire = pool_side[i] ? (c.tp <= pool_trig[i]) : (c.tp >= pool_trig[i]);
						if (pool_active[i] && fire) begin
							pool_active[i] = 1'b0;
							ev.push_back(slot_event(i, RES_TRIGGERED,
								pool_kind[i] ? pool_lim[i] : 32'sd0));
						end
					end
			end
		endcase
		if (ev.size() > 0) ev[ev.size()-1].lst = 1'b1;
		foreach (ev[k]) expected_events.push_back(ev[k]);
	endtask

	function automatic order_cmd_t blank_cmd(func_t f);
		order_cmd_t c;
		c.fn = f; c.kind = 1'($urandom_range(0, 1)); c.sd = 2'($urandom_range(0, 1));
		c.trig = $urandom_range(1, 1000); c.lim = 0; c.qty = $urandom_range(1, 500);
		c.ttl = 0; c.now_t = 64'd1000; c.id = $urandom_range(1, 40);
		c.tp = $urandom_range(1, 1000);
		if (c.kind) c.lim = $urandom_range(1, 1000);
		return c;
	endfunction

	function automatic order_cmd_t rand_cmd(logic [63:0] t);
		order_cmd_t c;
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 50) begin
			c = blank_cmd(FN_SUBMIT);
			if ($urandom_range(0, 3) == 0) c.ttl = 64'($urandom_range(1, 3000));
			if ($urandom_range(0, 19) == 0) c.ttl = {$urandom, $urandom};
			if ($urandom_range(0, 9) == 0) c.trig = $urandom;
			if (c.kind && $urandom_range(0, 9) == 0) c.lim = $urandom;
			if ($urandom_range(0, 9) == 0) c.qty = $urandom;
			if ($urandom_range(0, 9) == 0) begin
				c.sd = 2'($urandom); c.lim = $urandom; c.qty = $urandom_range(0, 1);
			end
			c.id = {$urandom_range(0, 1) ? 27'd0 : 27'($urandom), 5'($urandom)};
		end else if (pick < 65) begin
			c = blank_cmd(FN_CANCEL);
			if (live_ids.size() > 0 && $urandom_range(0, 2) != 0)
				c.id = live_ids[$urandom_range(0, live_ids.size() - 1)];
			else c.id = $urandom;
		end else if (pick < 75) begin
			c = blank_cmd(FN_EXPIRE);
		end else begin
			c = blank_cmd(FN_TRADE);
			if ($urandom_range(0, 9) == 0) c.tp = $urandom;
			if ($urandom_range(0, 19) == 0) c.tp = 0;
		end
		if (c.fn != FN_EXPIRE) begin
			c.now_t = t;
			if ($urandom_range(0, 9) == 0) c.now_t = {$urandom, $urandom};
		end else c.now_t = t;
		return c;
	endfunction

	// driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) begin
				predict_pool(cmd_queue.pop_front());
			end
			if ((!in_valid || in_ready) ) begin
				if (cmd_queue.size() > 0 && !hold_sender && (calm || $urandom_range(0, 99) >= 10)) begin
					in_valid      <= 1'b1;
					func          <= cmd_queue[0].fn;
					stop_kind     <= cmd_queue[0].kind;
					side          <= cmd_queue[0].sd;
					trig_px       <= cmd_queue[0].trig;
					lmt_px        <= cmd_queue[0].lim;
					quantity      <= cmd_queue[0].qty;
					time_to_live  <= cmd_queue[0].ttl;
					now_time      <= cmd_queue[0].now_t;
					ord_ref       <= cmd_queue[0].id;
					trade_price   <= cmd_queue[0].tp;
				end else
					in_valid <= 1'b0;
			end
		end
	end

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		errors++;
		$display("mismatch %s: got %0h want %0h", what, got, want);
	endtask

	// monitor
	always @(posedge clk) begin
		pool_event_t w;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (expected_events.size() == 0)
					report_mismatch("unexpected beat", 64'(event_res), 64'd0);
				else begin
					w = expected_events.pop_front();
					if (event_res != w.res)
						report_mismatch("event_res", 64'(event_res), 64'(w.res));
					if (event_order_id != w.id)
						report_mismatch("event_order_id", 64'(event_order_id), 64'(w.id));
					if (event_side != w.sd)
						report_mismatch("event_side", 64'(event_side), 64'(w.sd));
					if (event_kind != w.kind)
						report_mismatch("event_kind", 64'(event_kind), 64'(w.kind));
					if (event_trigger_price != w.trig)
						report_mismatch("event_trigger_price", 64'(unsigned'(event_trigger_price)),
							64'(unsigned'(w.trig)));
					if (reissue_price != w.reis)
						report_mismatch("reissue_price", 64'(unsigned'(reissue_price)),
							64'(unsigned'(w.reis)));
					if (event_quantity != w.qty)
						report_mismatch("event_quantity", 64'(event_quantity), 64'(w.qty));
					if (last != w.lst) report_mismatch("last", 64'(last), 64'(w.lst));
				end
			end
			out_ready <= calm || ($urandom_range(0, 99) >= 10);
		end
	end

	// directed beats are queued before stimulus flows; the driver consumes in order
	task automatic push(input order_cmd_t c);
		cmd_queue.push_back(c);
	endtask

	initial begin
		order_cmd_t c;
		logic [63:0] t;
		for (int i = 0; i < POOL_DEPTH; i++) pool_active[i] = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// directed: rejects in check order
		c = blank_cmd(FN_SUBMIT); c.qty = 0; push(c);
		c = blank_cmd(FN_SUBMIT); c.sd = 2'd3; c.trig = 32'sh8000_0000; push(c);
		c = blank_cmd(FN_SUBMIT); c.trig = 0; push(c);
		c = blank_cmd(FN_SUBMIT); c.kind = 0; c.lim = 32'sh7fff_ffff; push(c);
		c = blank_cmd(FN_SUBMIT); c.kind = 1; c.lim = 32'sh8000_0000; push(c);
		c = blank_cmd(FN_CANCEL); c.id = 32'hffff_ffff; push(c);
		// fill the pool past full, with duplicate ids and a saturating expiry
		for (int i = 0; i < POOL_DEPTH + 1; i++) begin
			c = blank_cmd(FN_SUBMIT); c.id = (i < 2) ? 32'd7 : 32'(i);
			c.qty = (i == 3) ? '1 : c.qty;
			c.trig = (i == 4) ? 32'sh7fff_ffff : c.trig;
			c.ttl = (i == 5) ? '1 : (i < 8 ? 64'd50 : 64'd0);
			c.now_t = (i == 5) ? 64'hffff_ffff_ffff_0000 : 64'd1000;
			push(c);
		end
		c = blank_cmd(FN_CANCEL); c.id = 7; push(c);
		c = blank_cmd(FN_EXPIRE); c.now_t = 64'd1050; push(c);
		c = blank_cmd(FN_TRADE); c.tp = 0; push(c);
		c = blank_cmd(FN_TRADE); c.tp = 32'sh7fff_ffff; push(c);
		c = blank_cmd(FN_TRADE); c.tp = 32'sh8000_0001; push(c);
		c = blank_cmd(FN_EXPIRE); c.now_t = '1; push(c);

		// pause until everything drained
		wait (cmd_queue.size() == 0 && !in_valid);
		hold_sender = 1'b1;
		wait (expected_events.size() == 0);
		repeat (80) @(posedge clk);
		hold_sender = 1'b0;

		t = 64'd2000;
		for (int n = 0; n < 235; n++) begin
			t += $urandom_range(0, 400);
			calm = (n >= 100 && n < 150);
			push(rand_cmd(t));
			wait (cmd_queue.size() < 4);
		end
		wait (cmd_queue.size() == 0 && !in_valid);
		wait (expected_events.size() == 0);
		repeat (100) @(posedge clk);
		if (errors == 0)
			$display("stop_order_trigger_pool_test: done, clean");
		else
			$display("stop_order_trigger_pool_test: done, errors");
		$finish;
	end

	initial begin
		#20ms;
		$display("stop_order_trigger_pool_test: done, errors");
		$finish;
	end

endmodule
